// ----- hw/rtl/fir_pkg.sv -----
// ----------------------------------------------------------------------------
// fir_pkg
// shared types and constants of the streaming fir filter
// ----------------------------------------------------------------------------
package fir_pkg;

   // item kinds carried on the request tuser
   localparam logic [1:0] FUNC_FILTER = 2'd0;
   localparam logic [1:0] FUNC_COEF   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam int SAMPLE_W = 32;
   localparam int COEF_W   = 18;
   localparam int INDEX_W  = 6;
   localparam int TAPS_W   = 7;
   localparam int PROD_W   = SAMPLE_W + COEF_W;

   localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd64;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   // commands from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic acc_clear;
      logic round;
   } mac_ctrl_type;

endpackage

// ----- hw/rtl/fir_tap_mem.sv -----
// ----------------------------------------------------------------------------
// fir_tap_mem
// history and coefficient memories with the shift-and-fetch read path
// ----------------------------------------------------------------------------
module fir_tap_mem import fir_pkg::*; #(
   parameter int MAX_TAP_COUNT = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  hist_clear,
   input  logic                                  coef_wr_en,
   input  logic [$clog2(MAX_TAP_COUNT)-1:0]      coef_wr_addr,
   input  logic signed [COEF_W-1:0]              coef_wr_data,
   input  logic                                  rd_en,
   input  logic [$clog2(MAX_TAP_COUNT)-1:0]      rd_addr,
   input  logic signed [SAMPLE_W-1:0]            sample,
   output logic                                  tap_valid,
   output logic signed [SAMPLE_W-1:0]            hist_value,
   output logic signed [COEF_W-1:0]              coef_value
);

   localparam int TAP_W = $clog2(MAX_TAP_COUNT);

   logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAP_COUNT];
   logic signed [COEF_W-1:0]   coef_mem [MAX_TAP_COUNT];

   logic [MAX_TAP_COUNT-1:0] hist_vld_ff, hist_vld_in;
   logic [MAX_TAP_COUNT-1:0] coef_vld_ff, coef_vld_in;

   logic                       rd_valid_ff;
   logic [TAP_W-1:0]           rd_addr_ff;
   logic signed [SAMPLE_W-1:0] hist_q_ff;
   logic signed [COEF_W-1:0]   coef_q_ff;
   logic                       hist_q_vld_ff;
   logic                       coef_q_vld_ff;
   logic [TAP_W-1:0]           hist_rd_addr;

   // the entry below the tap feeds it during the shift
   assign hist_rd_addr = rd_addr - TAP_W'(1);

   // tap zero takes the new sample, an unwritten entry reads as zero
   assign tap_valid  = rd_valid_ff;
   assign hist_value = (rd_addr_ff == '0) ? sample : (hist_q_vld_ff ? hist_q_ff : '0);
   assign coef_value = coef_q_vld_ff ? coef_q_ff : '0;

   always_comb begin
      hist_vld_in = hist_vld_ff;
      if (hist_clear) begin
         hist_vld_in = '0;
      end else if (rd_valid_ff) begin
         hist_vld_in[rd_addr_ff] = 1'b1;
      end
   end

   always_comb begin
      coef_vld_in = coef_vld_ff;
      if (coef_wr_en) begin
         coef_vld_in[coef_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         coef_vld_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         hist_vld_ff <= hist_vld_in;
         coef_vld_ff <= coef_vld_in;
         rd_valid_ff <= rd_en;
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_addr_ff    <= rd_addr;
         hist_q_ff     <= hist_mem[hist_rd_addr];
         hist_q_vld_ff <= hist_vld_ff[hist_rd_addr];
         coef_q_ff     <= coef_mem[rd_addr];
         coef_q_vld_ff <= coef_vld_ff[rd_addr];
      end
   end

   // write ports: shifted history goes back one entry up
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         hist_mem[rd_addr_ff] <= hist_value;
      end
   end

   always_ff @(posedge clock) begin
      if (coef_wr_en) begin
         coef_mem[coef_wr_addr] <= coef_wr_data;
      end
   end

endmodule

// ----- hw/rtl/fir_mac.sv -----
// ----------------------------------------------------------------------------
// fir_mac
// shared multiply-accumulate unit with truncation and saturation
// ----------------------------------------------------------------------------
module fir_mac import fir_pkg::*; #(
   parameter int MAX_TAP_COUNT  = 64,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctrl_type               ctrl,
   input  logic                       tap_valid,
   input  logic signed [SAMPLE_W-1:0] hist_value,
   input  logic signed [COEF_W-1:0]   coef_value,
   output logic                       idle,
   output logic signed [SAMPLE_W-1:0] sat_value
);

   localparam int SUM_W = PROD_W + $clog2(MAX_TAP_COUNT);
   localparam int ACC_W = (SUM_W > COEF_FRAC_BITS + SAMPLE_W + 1) ?
                          SUM_W : COEF_FRAC_BITS + SAMPLE_W + 1;
   localparam int SH_W  = ACC_W - COEF_FRAC_BITS;

   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  bias;
   logic signed [ACC_W-1:0]  biased;
   logic signed [SH_W-1:0]   shift_ff;
   logic [SH_W-SAMPLE_W:0]   upper;

   assign prod_in = hist_value * coef_value;
   assign idle    = ~tap_valid & ~prod_vld_ff;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // truncate toward zero: bias negative sums before the shift
   assign bias   = acc_ff[ACC_W-1] ? ACC_W'({COEF_FRAC_BITS{1'b1}}) : '0;
   assign biased = acc_ff + bias;

   // saturate when the bits above the int32 sign disagree
   assign upper = shift_ff[SH_W-1:SAMPLE_W-1];
   always_comb begin
      if ((&upper) || ~(|upper)) begin
         sat_value = shift_ff[SAMPLE_W-1:0];
      end else if (shift_ff[SH_W-1]) begin
         sat_value = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= tap_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (ctrl.round) begin
         shift_ff <= biased[ACC_W-1:COEF_FRAC_BITS];
      end
   end

endmodule

// ----- hw/rtl/fir_filter_streaming.sv -----
// ----------------------------------------------------------------------------
// fir_filter_streaming
// direct-form fir filter with one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// Each request transfer carries one of three kinds of item, chosen by tuser:
// filter a sample, write one coefficient, or clear the history. A sample
// shifts the first num_taps history entries up by one, puts the sample at
// tap zero and returns the sum of history times coefficient over those taps,
// taken as signed Q.COEF_FRAC_BITS, truncated toward zero and saturated to
// int32. A clear zeroes the history and returns 0; a coefficient write
// returns nothing. tlast is copied to the response. num_taps of 0 acts as 1
// and values above MAX_TAP_COUNT act as MAX_TAP_COUNT. For a sample the
// single multiplier walks the taps one per cycle from the top down, reading
// and rewriting the history memory on the way; then the multiply, accumulate
// and round stages drain and the response register is loaded. A coefficient
// write is done as it is accepted and leaves the block idle. The response
// register lets the next item start while a result still waits; a finished
// result holds the block only while that register is full. History and
// coefficients start at zero after reset with no clearing pass.
// csr_wr_en writes num_taps and is meant for idle periods.
// ----------------------------------------------------------------------------
module fir_filter_streaming import fir_pkg::*; #(
   parameter int MAX_TAP_COUNT  = 64,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic [TAPS_W-1:0]   csr_wr_data,   // num_taps
   // request channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [55:0]         req_tdata,     // sample[31:0], coef_index[37:32], coef_value[55:38]
   input  logic [1:0]          req_tuser,     // func[1:0]
   input  logic                req_tlast,     // end_flag
   // response channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,     // filtered[31:0]
   output logic                rsp_tlast      // end_out
);

   localparam int TAP_W = $clog2(MAX_TAP_COUNT);
   localparam int CNT_W = ($clog2(MAX_TAP_COUNT + 1) > TAPS_W) ?
                          $clog2(MAX_TAP_COUNT + 1) : TAPS_W;

   state_type state_ff, state_in;

   logic [TAPS_W-1:0]          num_taps_ff;
   logic [TAP_W-1:0]           idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       last_ff;
   logic                       zero_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff;
   logic                       rsp_last_ff;

   // request fields
   logic                       req_xfer;
   logic signed [SAMPLE_W-1:0] sample_field;
   logic [INDEX_W-1:0]         in_index;
   logic signed [COEF_W-1:0]   in_coef;

   // tap count in use and the index the walk starts at
   logic [CNT_W-1:0]           taps_ext;
   logic [CNT_W-1:0]           taps_used;
   logic [TAP_W-1:0]           last_idx;

   // sequencer outputs
   logic                       hist_clear;
   logic                       coef_wr_en;
   logic                       rd_en;
   logic                       rsp_load;
   mac_ctrl_type               mac_ctrl;

   // datapath links
   logic                       tap_valid;
   logic signed [SAMPLE_W-1:0] hist_value;
   logic signed [COEF_W-1:0]   coef_value;
   logic                       mac_idle;
   logic signed [SAMPLE_W-1:0] sat_value;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_xfer     = req_tvalid & req_tready;
   assign sample_field = req_tdata[31:0];
   assign in_index     = req_tdata[37:32];
   assign in_coef      = req_tdata[55:38];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      taps_ext = CNT_W'(num_taps_ff);
      if (taps_ext == '0) begin
         taps_used = CNT_W'(1);
      end else if (taps_ext > CNT_W'(MAX_TAP_COUNT)) begin
         taps_used = CNT_W'(MAX_TAP_COUNT);
      end else begin
         taps_used = taps_ext;
      end
      last_idx = TAP_W'(taps_used - CNT_W'(1));
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      hist_clear = 1'b0;
      coef_wr_en = 1'b0;
      rd_en      = 1'b0;
      rsp_load   = 1'b0;
      mac_ctrl   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_tuser)
                  FUNC_FILTER: begin
                     idx_in            = last_idx;
                     mac_ctrl.acc_clear = 1'b1;
                     state_in          = ST_RUN;
                  end
                  FUNC_COEF: begin
                     // indexes past the memory are dropped
                     coef_wr_en = (int'(in_index) < MAX_TAP_COUNT);
                  end
                  FUNC_CLEAR: begin
                     hist_clear = 1'b1;
                     state_in   = ST_RESULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            // one tap per cycle, top tap first
            rd_en = 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff - TAP_W'(1);
            end
         end
         ST_DRAIN: begin
            if (mac_idle) begin
               mac_ctrl.round = 1'b1;
               state_in       = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_taps_ff  <= TAPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            num_taps_ff <= csr_wr_data;
         end
      end
   end

   // item payload and response register
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_xfer) begin
         sample_ff <= sample_field;
         last_ff   <= req_tlast;
         zero_ff   <= (req_tuser == FUNC_CLEAR);
      end
      if (rsp_load) begin
         rsp_data_ff <= zero_ff ? '0 : sat_value;
         rsp_last_ff <= last_ff;
      end
   end

   fir_tap_mem #(
      .MAX_TAP_COUNT (MAX_TAP_COUNT)
   ) u_tap_mem (
      .clock        (clock),
      .reset        (reset),
      .hist_clear   (hist_clear),
      .coef_wr_en   (coef_wr_en),
      .coef_wr_addr (TAP_W'(in_index)),
      .coef_wr_data (in_coef),
      .rd_en        (rd_en),
      .rd_addr      (idx_ff),
      .sample       (sample_ff),
      .tap_valid    (tap_valid),
      .hist_value   (hist_value),
      .coef_value   (coef_value)
   );

   fir_mac #(
      .MAX_TAP_COUNT  (MAX_TAP_COUNT),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .tap_valid  (tap_valid),
      .hist_value (hist_value),
      .coef_value (coef_value),
      .idle       (mac_idle),
      .sat_value  (sat_value)
   );

endmodule
